// ----- hdl/cwlg_pkg.sv -----
// ----------------------------------------------------------------------------
// cwlg_pkg
// Shared types, constants and fixed-point helpers for the capsule wireframe
// line generator.
// ----------------------------------------------------------------------------
package cwlg_pkg;

	// field widths
	localparam int LIW       = 13;   // line index / line total
	localparam int CFG_W     = 31;   // widest configuration register
	localparam int CNT_REG_W = 7;    // stack / slice count registers
	localparam int AXIS_W    = 2;
	localparam int REG_IDX_W = 3;
	localparam int CNT_W     = 18;   // internal line counts, fits 256 x 511
	localparam int COORD_W   = 32;

	// default parameter values
	localparam int DEF_MAX_STACKS = 64;
	localparam int DEF_MAX_SLICES = 64;

	// pipeline depths
	localparam int DEC_LAT  = 5;
	localparam int TURN_STG = 4;
	localparam int SIN_LAT  = 7;
	localparam int VTX_LAT  = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AXIS   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STACKS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SLICES = 3'd4;

	// axis codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

	// quarter turn in Q0.32
	localparam logic [31:0] QTR_TURN = 32'h4000_0000;

	// sine polynomial, Q2.30
	localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
	localparam logic signed [33:0] SIN_C1  = 34'sd1686629713;
	localparam logic signed [33:0] SIN_C3  = -34'sd693598668;
	localparam logic signed [33:0] SIN_C5  = 34'sd85569304;
	localparam logic signed [33:0] SIN_C7  = -34'sd5026995;
	localparam logic signed [33:0] SIN_C9  = 34'sd172272;

	// kind of vertex an endpoint refers to
	typedef enum logic [1:0] {
		VK_UP,
		VK_LO,
		VK_PTOP,
		VK_PBOT
	} vkind_t;

	// control carried alongside the angle pipeline
	typedef struct packed {
		vkind_t kind_a;
		vkind_t kind_b;
		logic   past;
	} sband_t;

	// Q30 product, sign-magnitude, truncated toward zero
	function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
	                                               input logic signed [33:0] b);
		logic        neg;
		logic [33:0] ma;
		logic [33:0] mb;
		logic [67:0] p;
		logic [33:0] mag;
		neg = a[33] ^ b[33];
		ma  = a[33] ? 34'(-a) : 34'(a);
		mb  = b[33] ? 34'(-b) : 34'(b);
		p   = ma * mb;
		mag = p[63:30];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- hdl/capsule_wireframe_line_generator.sv -----
// ----------------------------------------------------------------------------
// capsule_wireframe_line_generator
// Returns both endpoints of one line of a capsule wireframe, given its index.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with line_index. Output channel:
// out_valid / out_stall with the two endpoints, line_total and past_end.
// A transaction moves when valid is high and stall is low.
// The pipeline runs index decode (with the ring division), angle division,
// the sine polynomial and vertex assembly, in that order. One transaction
// is taken every cycle unless a finished result is stalled at the output.
// The pipeline moves as a whole: while a result sits in the output register
// and the receiver stalls, in_stall is raised and every stage holds.
// Configuration is a plain write port (wr_en, wr_index, wr_data), to be
// written only while the pipeline is empty; unknown indexes are ignored.
// Reset clears the valid bits and loads radius 1.0, height 1.0, axis y and
// 8 stacks by 8 slices. line_total follows the configuration directly.
// Indexes at or past line_total give zero endpoints with past_end set.
// ----------------------------------------------------------------------------
module capsule_wireframe_line_generator #(
	parameter int MAX_STACKS = cwlg_pkg::DEF_MAX_STACKS,
	parameter int MAX_SLICES = cwlg_pkg::DEF_MAX_SLICES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cwlg_pkg::LIW-1:0]       line_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             start_x,
	output logic signed [31:0]             start_y,
	output logic signed [31:0]             start_z,
	output logic signed [31:0]             end_x,
	output logic signed [31:0]             end_y,
	output logic signed [31:0]             end_z,
	output logic [cwlg_pkg::LIW-1:0]       line_total,
	output logic                           past_end,
	input  logic                           wr_en,
	input  logic [cwlg_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [cwlg_pkg::CFG_W-1:0]     wr_data
);
	import cwlg_pkg::*;

	localparam int KIW = $clog2(MAX_STACKS+1);
	localparam int SIW = $clog2(MAX_SLICES+1);
	localparam int LAT = DEC_LAT + TURN_STG + SIN_LAT + VTX_LAT;
	localparam int DLY = TURN_STG + SIN_LAT;

	logic [CFG_W-1:0] radius_q, height_q;
	logic [AXIS_W-1:0] axis_q;
	logic [CNT_REG_W-1:0] stacks_q, slices_q;

	logic [KIW-1:0] k_c;
	logic [SIW-1:0] s_c;
	logic [CNT_W-1:0] total_c, mid_c;
	logic en;
	logic [LAT:1] vld_s;

	logic [KIW-1:0] ia, ib;
	logic [SIW-1:0] ja, jb;
	sband_t sb_s5;
	sband_t sb_s [DLY];

	logic [31:0] phi_a, phi_b, th_a, th_b;
	logic signed [31:0] sphi_a, cphi_a, sth_a, cth_a;
	logic signed [31:0] sphi_b, cphi_b, sth_b, cth_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CFG_W'(65536);
			height_q <= CFG_W'(65536);
			axis_q   <= AXIS_Y;
			stacks_q <= CNT_REG_W'(8);
			slices_q <= CNT_REG_W'(8);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIUS: radius_q <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				REG_AXIS:   axis_q   <= wr_data[AXIS_W-1:0];
				REG_STACKS: stacks_q <= wr_data[CNT_REG_W-1:0];
				REG_SLICES: slices_q <= wr_data[CNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped counts and line totals
	always_comb begin
		if (stacks_q < CNT_REG_W'(2))
			k_c = KIW'(2);
		else if (int'(stacks_q) > MAX_STACKS)
			k_c = KIW'(MAX_STACKS);
		else
			k_c = KIW'(stacks_q);
		if (slices_q < CNT_REG_W'(3))
			s_c = SIW'(3);
		else if (int'(slices_q) > MAX_SLICES)
			s_c = SIW'(MAX_SLICES);
		else
			s_c = SIW'(slices_q);
	end

	assign total_c    = CNT_W'(s_c) * ((CNT_W'(k_c) << 1) - CNT_W'(1));
	assign mid_c      = ((CNT_W'(k_c) - CNT_W'(2)) << 1) * CNT_W'(s_c);
	assign line_total = total_c[LIW-1:0];

	// whole-pipeline advance
	assign en       = !(vld_s[LAT] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-1:1], in_valid};
	end

	assign out_valid = vld_s[LAT];

	// index decode
	cwlg_decode #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_SLICES(MAX_SLICES)
	) u_decode (
		.clk       (clk),
		.en        (en),
		.line_index(line_index),
		.k         (k_c),
		.s         (s_c),
		.total     (total_c),
		.mid       (mid_c),
		.ia        (ia),
		.ja        (ja),
		.ib        (ib),
		.jb        (jb),
		.sb        (sb_s5)
	);

	// sideband follows the angle and sine stages
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= sb_s5;
			for (int n = 1; n < DLY; n++) sb_s[n] <= sb_s[n-1];
		end
	end

	// angles as fractions of a turn
	cwlg_turn_div #(.DW(KIW+1)) u_phi_a (
		.clk(clk), .en(en), .hi({1'b0, ia}), .lo(32'(k_c)), .dv({k_c, 1'b0}),
		.quo(phi_a)
	);
	cwlg_turn_div #(.DW(KIW+1)) u_phi_b (
		.clk(clk), .en(en), .hi({1'b0, ib}), .lo(32'(k_c)), .dv({k_c, 1'b0}),
		.quo(phi_b)
	);
	cwlg_turn_div #(.DW(SIW)) u_th_a (
		.clk(clk), .en(en), .hi(ja), .lo(32'(s_c >> 1)), .dv(s_c), .quo(th_a)
	);
	cwlg_turn_div #(.DW(SIW)) u_th_b (
		.clk(clk), .en(en), .hi(jb), .lo(32'(s_c >> 1)), .dv(s_c), .quo(th_b)
	);

	// sines and cosines, cos taken as sine a quarter turn later
	cwlg_sin u_sphi_a (.clk(clk), .en(en), .turn(phi_a), .sin_val(sphi_a));
	cwlg_sin u_cphi_a (.clk(clk), .en(en), .turn(phi_a + QTR_TURN), .sin_val(cphi_a));
	cwlg_sin u_sth_a  (.clk(clk), .en(en), .turn(th_a), .sin_val(sth_a));
	cwlg_sin u_cth_a  (.clk(clk), .en(en), .turn(th_a + QTR_TURN), .sin_val(cth_a));
	cwlg_sin u_sphi_b (.clk(clk), .en(en), .turn(phi_b), .sin_val(sphi_b));
	cwlg_sin u_cphi_b (.clk(clk), .en(en), .turn(phi_b + QTR_TURN), .sin_val(cphi_b));
	cwlg_sin u_sth_b  (.clk(clk), .en(en), .turn(th_b), .sin_val(sth_b));
	cwlg_sin u_cth_b  (.clk(clk), .en(en), .turn(th_b + QTR_TURN), .sin_val(cth_b));

	// endpoint assembly, outputs are registered inside
	cwlg_vertex u_vtx_a (
		.clk(clk), .en(en), .radius(radius_q), .half(height_q[CFG_W-1:1]),
		.axis(axis_q), .kind(sb_s[DLY-1].kind_a), .zero(sb_s[DLY-1].past),
		.sin_phi(sphi_a), .cos_phi(cphi_a), .sin_th(sth_a), .cos_th(cth_a),
		.vx(start_x), .vy(start_y), .vz(start_z)
	);
	cwlg_vertex u_vtx_b (
		.clk(clk), .en(en), .radius(radius_q), .half(height_q[CFG_W-1:1]),
		.axis(axis_q), .kind(sb_s[DLY-1].kind_b), .zero(sb_s[DLY-1].past),
		.sin_phi(sphi_b), .cos_phi(cphi_b), .sin_th(sth_b), .cos_th(cth_b),
		.vx(end_x), .vy(end_y), .vz(end_z)
	);

	// past-end flag travels with the last stage
	logic past_s17, past_s18, past_s19;
	always_ff @(posedge clk) begin
		if (en) begin
			past_s17 <= sb_s[DLY-1].past;
			past_s18 <= past_s17;
			past_s19 <= past_s18;
		end
	end
	assign past_end = past_s19;

	// past-end results carry zero endpoints
	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && past_end |-> start_x == 0 && start_y == 0 && start_z == 0 &&
		end_x == 0 && end_y == 0 && end_z == 0)
		else $error("past-end result with nonzero endpoint");

	// input is held exactly when a finished result is stalled
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	// a held result keeps its flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(past_end) && $stable(start_x))
		else $error("stalled result changed");

endmodule

// ----- hdl/cwlg_decode.sv -----
// ----------------------------------------------------------------------------
// cwlg_decode
// Maps a line index to the stack and slice of both endpoints: region split,
// ring division by twice the slice count, index and kind selection.
// ----------------------------------------------------------------------------
module cwlg_decode #(
	parameter int MAX_STACKS = 64,
	parameter int MAX_SLICES = 64
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [cwlg_pkg::LIW-1:0]        line_index,
	input  logic [$clog2(MAX_STACKS+1)-1:0] k,
	input  logic [$clog2(MAX_SLICES+1)-1:0] s,
	input  logic [cwlg_pkg::CNT_W-1:0]      total,
	input  logic [cwlg_pkg::CNT_W-1:0]      mid,
	output logic [$clog2(MAX_STACKS+1)-1:0] ia,
	output logic [$clog2(MAX_SLICES+1)-1:0] ja,
	output logic [$clog2(MAX_STACKS+1)-1:0] ib,
	output logic [$clog2(MAX_SLICES+1)-1:0] jb,
	output cwlg_pkg::sband_t                sb
);
	import cwlg_pkg::*;

	localparam int KIW = $clog2(MAX_STACKS+1);
	localparam int SIW = $clog2(MAX_SLICES+1);
	localparam int RW  = SIW + 1;
	localparam int DIV_A = (LIW + 1) / 2;
	localparam int DIV_B = LIW - DIV_A;

	typedef enum logic [1:0] {RG_TOP, RG_MID, RG_LAST, RG_BOT} rgn_t;

	logic [LIW-1:0] li_s1;
	logic [CNT_W-1:0] li_w, s_w, m_w;
	rgn_t rgn_c;
	logic [SIW-1:0] je_c;

	logic [LIW-1:0] m_s2;
	rgn_t rgn_s2;
	logic [SIW-1:0] je_s2;
	logic past_s2;

	logic [RW-1:0] rem_c3, rem_s3;
	logic [LIW-1:0] num_c3, num_s3, quo_c3, quo_s3;
	rgn_t rgn_s3;
	logic [SIW-1:0] je_s3;
	logic past_s3;

	logic [RW-1:0] rem_c4, rem_s4;
	logic [LIW-1:0] quo_c4, quo_s4;
	rgn_t rgn_s4;
	logic [SIW-1:0] je_s4;
	logic past_s4;

	logic [RW-1:0] d2;
	logic [KIW-1:0] ring1, ia_c, ib_c;
	logic [SIW-1:0] jm, ja_c, jb_c, jb_w;

	// input register
	always_ff @(posedge clk) begin
		if (en) li_s1 <= line_index;
	end

	// region split
	assign li_w = CNT_W'(li_s1);
	assign s_w  = CNT_W'(s);
	assign m_w  = li_w - s_w;

	always_comb begin
		if (li_w < s_w) begin
			rgn_c = RG_TOP;
			je_c  = SIW'(li_w);
		end else if (m_w < mid) begin
			rgn_c = RG_MID;
			je_c  = '0;
		end else if ((m_w - mid) < s_w) begin
			rgn_c = RG_LAST;
			je_c  = SIW'(m_w - mid);
		end else begin
			rgn_c = RG_BOT;
			je_c  = SIW'(m_w - mid - s_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= m_w[LIW-1:0];
			rgn_s2  <= rgn_c;
			je_s2   <= je_c;
			past_s2 <= (li_w >= total);
		end
	end

	// ring division, first half of the quotient bits
	assign d2 = {s, 1'b0};

	always_comb begin : div_a
		logic [RW:0] r2;
		rem_c3 = '0;
		num_c3 = m_s2;
		quo_c3 = '0;
		for (int b = 0; b < DIV_A; b++) begin
			r2 = {rem_c3, num_c3[LIW-1]};
			num_c3 = num_c3 << 1;
			if (r2 >= {1'b0, d2}) begin
				r2 = r2 - {1'b0, d2};
				quo_c3 = {quo_c3[LIW-2:0], 1'b1};
			end else begin
				quo_c3 = {quo_c3[LIW-2:0], 1'b0};
			end
			rem_c3 = r2[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3  <= rem_c3;
			num_s3  <= num_c3;
			quo_s3  <= quo_c3;
			rgn_s3  <= rgn_s2;
			je_s3   <= je_s2;
			past_s3 <= past_s2;
		end
	end

	// ring division, remaining quotient bits
	always_comb begin : div_b
		logic [RW:0] r2;
		logic [LIW-1:0] n;
		rem_c4 = rem_s3;
		n = num_s3;
		quo_c4 = quo_s3;
		for (int b = 0; b < DIV_B; b++) begin
			r2 = {rem_c4, n[LIW-1]};
			n = n << 1;
			if (r2 >= {1'b0, d2}) begin
				r2 = r2 - {1'b0, d2};
				quo_c4 = {quo_c4[LIW-2:0], 1'b1};
			end else begin
				quo_c4 = {quo_c4[LIW-2:0], 1'b0};
			end
			rem_c4 = r2[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4  <= rem_c4;
			quo_s4  <= quo_c4;
			rgn_s4  <= rgn_s3;
			je_s4   <= je_s3;
			past_s4 <= past_s3;
		end
	end

	// endpoint selection
	assign ring1 = KIW'(quo_s4) + KIW'(1);
	assign jm    = rem_s4[SIW:1];

	always_comb begin
		unique case (rgn_s4)
			RG_TOP: begin
				ia_c = '0;
				ja_c = '0;
				ib_c = KIW'(1);
				jb_c = je_s4;
			end
			RG_MID: begin
				ia_c = ring1;
				ja_c = jm;
				if (!rem_s4[0]) begin
					ib_c = ring1 + KIW'(1);
					jb_c = jm;
				end else begin
					ib_c = ring1;
					jb_c = jm + SIW'(1);
				end
			end
			RG_LAST: begin
				ia_c = k - KIW'(1);
				ja_c = je_s4;
				ib_c = k - KIW'(1);
				jb_c = je_s4 + SIW'(1);
			end
			default: begin
				ia_c = k;
				ja_c = '0;
				ib_c = k - KIW'(1);
				jb_c = je_s4;
			end
		endcase
	end

	// slice past the last one wraps to slice zero
	assign jb_w = (jb_c >= s) ? jb_c - s : jb_c;

	function automatic vkind_t kind_of(input logic [KIW-1:0] i, input logic [KIW-1:0] kk);
		vkind_t r;
		if (i == '0)
			r = VK_PTOP;
		else if (i >= kk)
			r = VK_PBOT;
		else if (i <= (kk >> 1))
			r = VK_UP;
		else
			r = VK_LO;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ia        <= ia_c;
			ja        <= ja_c;
			ib        <= ib_c;
			jb        <= jb_w;
			sb.kind_a <= kind_of(ia_c, k);
			sb.kind_b <= kind_of(ib_c, k);
			sb.past   <= past_s4;
		end
	end

endmodule

// ----- hdl/cwlg_turn_div.sv -----
// ----------------------------------------------------------------------------
// cwlg_turn_div
// Pipelined restoring divider producing a Q0.32 angle:
// (hi * 2^32 + lo) / dv, with hi below dv, eight quotient bits per stage.
// ----------------------------------------------------------------------------
module cwlg_turn_div #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] hi,
	input  logic [31:0]   lo,
	input  logic [DW-1:0] dv,
	output logic [31:0]   quo
);
	import cwlg_pkg::*;

	localparam int STEPS = 32 / TURN_STG;

	logic [DW-1:0] rem_s [TURN_STG+1];
	logic [31:0]   num_s [TURN_STG+1];
	logic [31:0]   quo_s [TURN_STG+1];

	assign rem_s[0] = hi;
	assign num_s[0] = lo;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < TURN_STG; g++) begin : g_stage
		logic [DW-1:0] rem_c;
		logic [31:0]   num_c;
		logic [31:0]   quo_c;

		// one quotient bit per step
		always_comb begin : steps
			logic [DW:0] r2;
			rem_c = rem_s[g];
			num_c = num_s[g];
			quo_c = quo_s[g];
			for (int b = 0; b < STEPS; b++) begin
				r2 = {rem_c, num_c[31]};
				num_c = num_c << 1;
				if (r2 >= {1'b0, dv}) begin
					r2 = r2 - {1'b0, dv};
					quo_c = {quo_c[30:0], 1'b1};
				end else begin
					quo_c = {quo_c[30:0], 1'b0};
				end
				rem_c = r2[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_c;
				num_s[g+1] <= num_c;
				quo_s[g+1] <= quo_c;
			end
		end
	end

	assign quo = quo_s[TURN_STG];

endmodule

// ----- hdl/cwlg_sin.sv -----
// ----------------------------------------------------------------------------
// cwlg_sin
// Pipelined Q2.30 sine of a Q0.32 turn: quadrant fold, odd polynomial by
// Horner, one multiply per stage, clamp and sign.
// ----------------------------------------------------------------------------
module cwlg_sin (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        turn,
	output logic signed [31:0] sin_val
);
	import cwlg_pkg::*;

	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic signed [33:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic signed [33:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic signed [33:0] t_s3, t_s4, t_s5, t_s6;
	logic signed [33:0] y_c;
	logic signed [31:0] y_s7;

	// quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= turn[31:30];
			x_s1    <= turn[30] ? Q30_ONE - $signed({4'b0, turn[29:0]})
			                    : $signed({4'b0, turn[29:0]});
		end
	end

	// square and Horner steps
	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2   <= mul_q30(x_s1, x_s1);
			x_s2    <= x_s1;
			quad_s2 <= quad_s1;

			t_s3    <= SIN_C7 + mul_q30(SIN_C9, x2_s2);
			x2_s3   <= x2_s2;
			x_s3    <= x_s2;
			quad_s3 <= quad_s2;

			t_s4    <= SIN_C5 + mul_q30(t_s3, x2_s3);
			x2_s4   <= x2_s3;
			x_s4    <= x_s3;
			quad_s4 <= quad_s3;

			t_s5    <= SIN_C3 + mul_q30(t_s4, x2_s4);
			x2_s5   <= x2_s4;
			x_s5    <= x_s4;
			quad_s5 <= quad_s4;

			t_s6    <= SIN_C1 + mul_q30(t_s5, x2_s5);
			x_s6    <= x_s5;
			quad_s6 <= quad_s5;
		end
	end

	// final multiply, clamp to [0, 1], sign from quadrant
	always_comb begin
		y_c = mul_q30(t_s6, x_s6);
		if (y_c > Q30_ONE) y_c = Q30_ONE;
		if (y_c < 0) y_c = '0;
		if (quad_s6[1]) y_c = -y_c;
	end

	always_ff @(posedge clk) begin
		if (en) y_s7 <= y_c[31:0];
	end

	assign sin_val = y_s7;

endmodule

// ----- hdl/cwlg_vertex.sv -----
// ----------------------------------------------------------------------------
// cwlg_vertex
// Builds one endpoint from its sines and cosines: radius scaling, ring
// coordinates, axis offset or pole position, axis placement.
// ----------------------------------------------------------------------------
module cwlg_vertex (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cwlg_pkg::CFG_W-1:0]  radius,
	input  logic [cwlg_pkg::CFG_W-2:0]  half,
	input  logic [cwlg_pkg::AXIS_W-1:0] axis,
	input  cwlg_pkg::vkind_t            kind,
	input  logic                        zero,
	input  logic signed [31:0]          sin_phi,
	input  logic signed [31:0]          cos_phi,
	input  logic signed [31:0]          sin_th,
	input  logic signed [31:0]          cos_th,
	output logic signed [31:0]          vx,
	output logic signed [31:0]          vy,
	output logic signed [31:0]          vz
);
	import cwlg_pkg::*;

	logic signed [33:0] r_w, h_w;
	logic signed [33:0] sp_w, ac_w;
	logic signed [31:0] sp_s1, ac_s1, sth_s1, cth_s1;
	vkind_t kind_s1;
	logic zero_s1;
	logic signed [31:0] p1_s2, p2_s2, ax_s2;
	logic zero_s2;
	logic signed [31:0] ax_c;

	function automatic logic signed [33:0] ext(input logic signed [31:0] v);
		return $signed({{2{v[31]}}, v});
	endfunction

	assign r_w = $signed({3'b0, radius});
	assign h_w = $signed({4'b0, half});

	// radius times sin and cos of the latitude
	assign sp_w = mul_q30(r_w, ext(sin_phi));
	assign ac_w = mul_q30(r_w, ext(cos_phi));

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1   <= sp_w[31:0];
			ac_s1   <= ac_w[31:0];
			sth_s1  <= sin_th;
			cth_s1  <= cos_th;
			kind_s1 <= kind;
			zero_s1 <= zero;
		end
	end

	// axis coordinate
	always_comb begin
		unique case (kind_s1)
			VK_PTOP: ax_c = sat32(r_w + h_w);
			VK_PBOT: ax_c = sat32(-h_w - r_w);
			VK_UP:   ax_c = sat32(ext(ac_s1) + h_w);
			default: ax_c = sat32(ext(ac_s1) - h_w);
		endcase
	end

	// ring coordinates, poles sit on the axis
	always_ff @(posedge clk) begin
		if (en) begin
			if (kind_s1 == VK_PTOP || kind_s1 == VK_PBOT) begin
				p1_s2 <= '0;
				p2_s2 <= '0;
			end else begin
				p1_s2 <= sat32(mul_q30(ext(sp_s1), ext(cth_s1)));
				p2_s2 <= sat32(mul_q30(ext(sp_s1), ext(sth_s1)));
			end
			ax_s2   <= ax_c;
			zero_s2 <= zero_s1;
		end
	end

	// placement along the chosen axis
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s2) begin
				vx <= '0;
				vy <= '0;
				vz <= '0;
			end else begin
				unique case (axis)
					AXIS_X: begin
						vx <= ax_s2;
						vy <= p1_s2;
						vz <= p2_s2;
					end
					AXIS_Y: begin
						vx <= p1_s2;
						vy <= ax_s2;
						vz <= p2_s2;
					end
					default: begin
						vx <= p1_s2;
						vy <= p2_s2;
						vz <= ax_s2;
					end
				endcase
			end
		end
	end

endmodule
